[rtl/greedy_full_text_justification_core_macros.svh]
// Assertion macros for the greedy text justification core.
// Used by the top level; depends on nothing else.
`ifndef GREEDY_FULL_TEXT_JUSTIFICATION_CORE_MACROS_SVH
`define GREEDY_FULL_TEXT_JUSTIFICATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GFTJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GFTJ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gftj_pkg.sv]
// Shared constants and interface structs of the greedy text justification core.
// No dependencies; used by the line RAM, the divider and the top level.
package gftj_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_WORDS   = 32;
    localparam int LEN_W       = 7;
    localparam int SPACE_W     = 6;
    localparam int IDX_W       = $clog2(MAX_WORDS);
    localparam int CNT_W       = $clog2(MAX_WORDS + 1);
    localparam int DIVD_W      = LEN_W;
    localparam int DIVR_W      = IDX_W;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Line buffer write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [LEN_W-1:0] data;
    } ram_wr_t;

    // Line buffer read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    // Divider response, quotient and remainder held until the next start
    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

endpackage

[rtl/gftj_line_ram.sv]
// Line buffer: one synchronous RAM holding the word lengths of the open line.
// Depends on gftj_pkg; one write and one read port, read data registered.
module gftj_line_ram (
    input  logic                       clk,
    input  gftj_pkg::ram_wr_t          wr,
    input  gftj_pkg::ram_rd_t          rd,
    output logic [gftj_pkg::LEN_W-1:0] rd_data
);

    logic [gftj_pkg::LEN_W-1:0] mem [gftj_pkg::MAX_WORDS];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read one entry, hold the data between reads
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

[rtl/gftj_divider.sv]
// Restoring divider, one quotient bit per cycle, for the gap spacing of a line.
// Depends on gftj_pkg for widths and the request and response structs.
module gftj_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  gftj_pkg::div_req_t req,
    output gftj_pkg::div_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [gftj_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [gftj_pkg::DIVR_W-1:0]      rem_reg, rem_next;
    logic [gftj_pkg::DIVD_W-1:0]      quo_reg, quo_next;
    logic [gftj_pkg::DIVR_W-1:0]      dsr_reg, dsr_next;
    logic [gftj_pkg::DIVR_W:0]        trial;
    logic                             take;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[gftj_pkg::DIVD_W-1]};
        take      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? gftj_pkg::DIVR_W'(trial - {1'b0, dsr_reg})
                            : trial[gftj_pkg::DIVR_W-1:0];
            quo_next = {quo_reg[gftj_pkg::DIVD_W-2:0], take};
            cnt_next = cnt_reg + gftj_pkg::DIV_CNT_W'(1);
            if (cnt_reg == gftj_pkg::DIV_CNT_W'(gftj_pkg::DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/greedy_full_text_justification_core.sv]
// Greedy full text justification core: usage summary and top level.
//
// Input stream: one transaction per word. s_axis_tdata carries the word
// length, s_axis_tlast marks the last word of the text and flushes the line.
// Output stream: one transaction per placed word with its length, the blanks
// after it, and flags for line end and overlong word; m_axis_tlast marks the
// last placement caused by one input word.
// Config channel: cfg_data writes the line width, taken in any cycle; write
// it only while no word is in flight.
// Sequence: a word that only extends the open line passes through the idle
// and decide states. Closing a line of n >= 2 words runs the gap division,
// then reads and places each word in turn, paced by the single read port of
// the line buffer RAM, and then opens the new line or places an overlong
// word; a final flush or a one-word line skips the division. After it, the
// first word is read from the RAM and then loaded into the output register.
// Reset clears the open line and sets the width to 64; the line buffer RAM
// needs no clearing. When the receiver stalls, the result waits in the output
// register and the core holds its sequence; the next word is taken once the
// core is back in its idle state, even with a result still waiting.
`include "greedy_full_text_justification_core_macros.svh"

module greedy_full_text_justification_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Line width register write
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gftj_pkg::LEN_W-1:0]              cfg_data,
    // Word stream in
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [gftj_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // word_length[6:0]
    input  logic                                    s_axis_tlast,  // final_word
    // Placement stream out
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [gftj_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // placed_length[6:0],
                                                                   // spaces_after[12:7]
    output logic [gftj_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,  // line_end[0],
                                                                   // overlong[1]
    output logic                                    m_axis_tlast   // run_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_EMIT_RD,
        S_EMIT_WR,
        S_OVL,
        S_APPEND
    } state_t;

    typedef enum logic {
        MODE_CLOSE,
        MODE_FLUSH
    } mode_t;

    typedef enum logic {
        AFTER_OVL,
        AFTER_APPEND
    } after_t;

    state_t                          state_reg, state_next;
    mode_t                           mode_reg, mode_next;
    after_t                          after_reg, after_next;
    logic [gftj_pkg::LEN_W-1:0]      width_reg, width_next;
    logic [gftj_pkg::CNT_W-1:0]      n_reg, n_next;
    logic [gftj_pkg::LEN_W-1:0]      used_reg, used_next;
    logic [gftj_pkg::LEN_W-1:0]      len_reg, len_next;
    logic                            fin_reg, fin_next;
    logic [gftj_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [gftj_pkg::IDX_W-1:0]      last_reg, last_next;
    logic                            out_valid_reg, out_valid_next;
    logic [gftj_pkg::LEN_W-1:0]      out_len_reg, out_len_next;
    logic [gftj_pkg::SPACE_W-1:0]    out_space_reg, out_space_next;
    logic                            out_end_reg, out_end_next;
    logic                            out_ovl_reg, out_ovl_next;
    logic                            out_last_reg, out_last_next;

    logic [gftj_pkg::LEN_W-1:0]      wc;
    logic [gftj_pkg::LEN_W-1:0]      in_len;
    logic                            ovl_word;
    logic [gftj_pkg::LEN_W:0]        fit_sum;
    logic                            fits;
    logic [gftj_pkg::CNT_W-1:0]      n_minus1;
    logic [gftj_pkg::IDX_W-1:0]      gaps;
    logic [gftj_pkg::LEN_W-1:0]      sum_len;
    logic [gftj_pkg::LEN_W-1:0]      total_raw;
    logic [gftj_pkg::LEN_W-1:0]      total;
    logic [gftj_pkg::LEN_W-1:0]      pad_single;
    logic [gftj_pkg::LEN_W-1:0]      pad_final;
    logic [gftj_pkg::LEN_W-1:0]      space_gap;
    logic                            at_last;
    logic                            can_load;

    gftj_pkg::ram_wr_t               ram_wr;
    gftj_pkg::ram_rd_t               ram_rd;
    logic [gftj_pkg::LEN_W-1:0]      ram_rd_data;
    gftj_pkg::div_req_t              div_req;
    gftj_pkg::div_rsp_t              div_rsp;

    gftj_line_ram u_line_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    gftj_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp the width register and the incoming length to their legal ranges
    always_comb
    begin
        if (width_reg == '0)
        begin
            wc = gftj_pkg::LEN_W'(1);
        end
        else if (width_reg > gftj_pkg::LEN_W'(gftj_pkg::MAX_WIDTH))
        begin
            wc = gftj_pkg::LEN_W'(gftj_pkg::MAX_WIDTH);
        end
        else
        begin
            wc = width_reg;
        end
        in_len = s_axis_tdata[gftj_pkg::LEN_W-1:0];
        if (in_len == '0)
        begin
            in_len = gftj_pkg::LEN_W'(1);
        end
    end

    // Fit test and gap spacing for the open line
    always_comb
    begin
        ovl_word  = len_reg > wc;
        fit_sum   = {1'b0, used_reg} + (gftj_pkg::LEN_W + 1)'(1) + {1'b0, len_reg};
        fits      = (n_reg == '0) ||
                    ((n_reg < gftj_pkg::CNT_W'(gftj_pkg::MAX_WORDS)) &&
                     (fit_sum <= {1'b0, wc}));
        n_minus1  = n_reg - gftj_pkg::CNT_W'(1);
        gaps      = n_minus1[gftj_pkg::IDX_W-1:0];
        sum_len   = (used_reg > gftj_pkg::LEN_W'(gaps)) ? used_reg - gftj_pkg::LEN_W'(gaps)
                                                        : '0;
        total_raw = (wc > sum_len) ? wc - sum_len : '0;
        total     = (total_raw < gftj_pkg::LEN_W'(gaps)) ? gftj_pkg::LEN_W'(gaps) : total_raw;
    end

    // Spacing of the word coming out of the line buffer
    always_comb
    begin
        pad_single = (wc > ram_rd_data) ? wc - ram_rd_data : '0;
        pad_final  = (wc > used_reg) ? wc - used_reg : '0;
        space_gap  = div_rsp.quotient +
                     gftj_pkg::LEN_W'(idx_reg < div_rsp.remainder);
        at_last    = idx_reg == last_reg;
        can_load   = !out_valid_reg || m_axis_tready;
    end

    // Line buffer and divider requests
    always_comb
    begin
        ram_wr.en   = ((state_reg == S_DECIDE) && !ovl_word && fits) ||
                      (state_reg == S_APPEND);
        ram_wr.addr = n_reg[gftj_pkg::IDX_W-1:0];
        ram_wr.data = len_reg;
        ram_rd.en   = state_reg == S_EMIT_RD;
        ram_rd.addr = idx_reg;
        div_req.start    = (state_reg == S_DECIDE) && (ovl_word || !fits) &&
                           (n_reg >= gftj_pkg::CNT_W'(2));
        div_req.dividend = total;
        div_req.divisor  = gaps;
    end

    // Sequence one word: decide, close or flush, place an overlong word, append
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        after_next     = after_reg;
        width_next     = cfg_valid ? cfg_data : width_reg;
        n_next         = n_reg;
        used_next      = used_reg;
        len_next       = len_reg;
        fin_next       = fin_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_len_next   = out_len_reg;
        out_space_next = out_space_reg;
        out_end_next   = out_end_reg;
        out_ovl_next   = out_ovl_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    len_next   = in_len;
                    fin_next   = s_axis_tlast;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (ovl_word || !fits)
                begin
                    mode_next  = MODE_CLOSE;
                    after_next = ovl_word ? AFTER_OVL : AFTER_APPEND;
                    idx_next   = '0;
                    last_next  = gaps;
                    if (ovl_word && (n_reg == '0))
                    begin
                        state_next = S_OVL;
                    end
                    else if (n_reg >= gftj_pkg::CNT_W'(2))
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    // Append to the open line
                    n_next    = n_reg + gftj_pkg::CNT_W'(1);
                    used_next = (n_reg == '0) ? len_reg : fit_sum[gftj_pkg::LEN_W-1:0];
                    if (fin_reg)
                    begin
                        mode_next  = MODE_FLUSH;
                        idx_next   = '0;
                        last_next  = n_reg[gftj_pkg::IDX_W-1:0];
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = ram_rd_data;
                    out_end_next   = at_last;
                    out_ovl_next   = 1'b0;
                    out_last_next  = at_last && ((mode_reg == MODE_FLUSH) ||
                                     ((after_reg == AFTER_APPEND) && !fin_reg));
                    if (mode_reg == MODE_FLUSH)
                    begin
                        out_space_next = at_last ? pad_final[gftj_pkg::SPACE_W-1:0]
                                                 : gftj_pkg::SPACE_W'(1);
                    end
                    else if (at_last)
                    begin
                        out_space_next = (last_reg == '0) ? pad_single[gftj_pkg::SPACE_W-1:0]
                                                          : '0;
                    end
                    else
                    begin
                        out_space_next = space_gap[gftj_pkg::SPACE_W-1:0];
                    end
                    if (at_last)
                    begin
                        n_next    = '0;
                        used_next = '0;
                        if (mode_reg == MODE_FLUSH)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (after_reg == AFTER_OVL)
                        begin
                            state_next = S_OVL;
                        end
                        else
                        begin
                            state_next = S_APPEND;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + gftj_pkg::IDX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_OVL:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = len_reg;
                    out_space_next = '0;
                    out_end_next   = 1'b1;
                    out_ovl_next   = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_APPEND:
            begin
                // Start a new line with the word that did not fit
                n_next    = gftj_pkg::CNT_W'(1);
                used_next = len_reg;
                if (fin_reg)
                begin
                    mode_next  = MODE_FLUSH;
                    idx_next   = '0;
                    last_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_CLOSE;
            after_reg     <= AFTER_APPEND;
            width_reg     <= gftj_pkg::LEN_W'(gftj_pkg::MAX_WIDTH);
            n_reg         <= '0;
            used_reg      <= '0;
            len_reg       <= '0;
            fin_reg       <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_space_reg <= '0;
            out_end_reg   <= 1'b0;
            out_ovl_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            after_reg     <= after_next;
            width_reg     <= width_next;
            n_reg         <= n_next;
            used_reg      <= used_next;
            len_reg       <= len_next;
            fin_reg       <= fin_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_len_reg   <= out_len_next;
            out_space_reg <= out_space_next;
            out_end_reg   <= out_end_next;
            out_ovl_reg   <= out_ovl_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Drive the ports
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(gftj_pkg::OUT_TDATA_W - gftj_pkg::LEN_W - gftj_pkg::SPACE_W){1'b0}},
                            out_space_reg, out_len_reg};
    assign m_axis_tuser  = {out_ovl_reg, out_end_reg};
    assign m_axis_tlast  = out_last_reg;

    // Checks on the sequencer
    `GFTJ_ASSERT_NXT(a_accept_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word taken while another is in flight")
    `GFTJ_ASSERT_IMP(a_empty_line, clk, rst_n, n_reg == '0, used_reg == '0, "empty line with nonzero length")
    `GFTJ_ASSERT_IMP(a_overlong_alone, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && m_axis_tlast, "overlong word not alone at end of run")
    `GFTJ_ASSERT_IMP(a_div_done, clk, rst_n, div_rsp.done, state_reg == S_DIV, "division finished outside its wait state")

endmodule
